>>> design/cursor_drawing_command_parser_core_defines.svh
// assertion macros used by the checker file of the command parser
`ifndef CURSOR_DRAWING_COMMAND_PARSER_CORE_DEFINES_SVH
`define CURSOR_DRAWING_COMMAND_PARSER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define CDCP_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define CDCP_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/cdcp_pkg.sv
// shared types and constants of the cursor drawing command parser
`default_nettype none

package cdcp_pkg;

	localparam int unsigned DIM_W = 13;
	localparam int unsigned POS_W = 12;

	// largest canvas side in pixels
	localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;

	// configuration register indexes
	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	typedef enum logic [2:0] {
		KIND_PIXEL = 3'd0,
		KIND_INFO  = 3'd1,
		KIND_SIZE  = 3'd2,
		KIND_STATS = 3'd3,
		KIND_HELP  = 3'd4,
		KIND_ERROR = 3'd5
	} result_kind_t;

	typedef enum logic [1:0] {
		ERR_EMPTY    = 2'd0,
		ERR_NO_COLOR = 2'd1,
		ERR_BAD_LEN  = 2'd2,
		ERR_UNKNOWN  = 2'd3
	} error_code_t;

	typedef struct packed {
		logic [7:0]       line_byte;
		logic [POS_W-1:0] rand_x;
		logic [POS_W-1:0] rand_y;
		logic [23:0]      rand_rgb;
	} cmd_t;

	typedef struct packed {
		result_kind_t     result_kind;
		logic [DIM_W-1:0] out_x;
		logic [DIM_W-1:0] out_y;
		logic [31:0]      out_color;
		logic [31:0]      pixel_total;
		error_code_t      error_code;
	} rsp_t;

endpackage

`default_nettype wire

>>> design/cursor_drawing_command_parser_core.sv
// Cursor drawing command parser: takes one command line a byte per word, ending at a zero
// byte, matches it by prefix against RESET, LEFT, RIGHT, UP, DOWN, "COLOR ", INFO, SIZE,
// STATS and HELP, and keeps the cursor, the drawing color and the pixel count. A cmd word
// is taken in every cycle in which the result register is free or being emptied, so the
// sustained rate is one byte per clock; all work for a byte is one pass of logic into the
// line-state registers, and a zero byte that yields a result loads it into the rsp register
// at the accepting edge, so it can be taken at the next edge at the earliest. cmd_stall is
// high only while that register holds a word that rsp_stall keeps. Canvas size resets to
// 1024 by 768; a written size of 0 acts as 1 and one above 4096 acts as 4096. Write the
// canvas registers only while the block is idle.
`default_nettype none

module cursor_drawing_command_parser_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [cdcp_pkg::DIM_W-1:0]      cfg_data,
	input  logic                            cmd_valid,
	output logic                            cmd_stall,
	input  cdcp_pkg::cmd_t                  cmd,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output cdcp_pkg::rsp_t                  rsp
);

	localparam int unsigned NUM_KW = 10;

	// keyword numbers, in match priority order
	localparam logic [3:0] KW_RESET = 4'd0;
	localparam logic [3:0] KW_LEFT  = 4'd1;
	localparam logic [3:0] KW_RIGHT = 4'd2;
	localparam logic [3:0] KW_UP    = 4'd3;
	localparam logic [3:0] KW_DOWN  = 4'd4;
	localparam logic [3:0] KW_COLOR = 4'd5;
	localparam logic [3:0] KW_INFO  = 4'd6;
	localparam logic [3:0] KW_SIZE  = 4'd7;
	localparam logic [3:0] KW_STATS = 4'd8;
	localparam logic [3:0] KW_HELP  = 4'd9;
	localparam logic [3:0] KW_NONE  = 4'd10;

	localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
		'{"R", "E", "S", "E", "T", 8'h00, 8'h00, 8'h00},
		'{"L", "E", "F", "T", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"R", "I", "G", "H", "T", 8'h00, 8'h00, 8'h00},
		'{"U", "P", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"D", "O", "W", "N", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"C", "O", "L", "O", "R", " ", 8'h00, 8'h00},
		'{"I", "N", "F", "O", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"S", "I", "Z", "E", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"S", "T", "A", "T", "S", 8'h00, 8'h00, 8'h00},
		'{"H", "E", "L", "P", 8'h00, 8'h00, 8'h00, 8'h00}
	};
	localparam logic [3:0] KW_LEN [NUM_KW] = '{
		4'd5, 4'd4, 4'd5, 4'd2, 4'd4, 4'd6, 4'd4, 4'd4, 4'd5, 4'd4
	};
	localparam logic [3:0] HEX_START = 4'd6;
	localparam logic [3:0] POS_MAX   = 4'd15;
	localparam logic [3:0] HEX_MAX   = 4'd9;
	localparam logic [3:0] HEX_KEEP  = 4'd8;
	localparam logic [4:0] HEX_NONE  = 5'd16;

	// canvas size, stored already clamped
	logic [cdcp_pkg::DIM_W-1:0] canvas_w_q, canvas_h_q;
	logic [cdcp_pkg::POS_W-1:0] cursor_x_q, cursor_y_q;
	logic [31:0]                color_q, pixels_q, hex_acc_q;
	logic [NUM_KW-1:0]          alive_q;
	logic [3:0]                 pos_q, hex_cnt_q;
	logic                       hex_stop_q;
	logic                       rsp_valid_q;
	cdcp_pkg::rsp_t             rsp_q;

	logic [cdcp_pkg::POS_W-1:0] cursor_x_d, cursor_y_d;
	logic [31:0]                color_d, pixels_d, hex_acc_d;
	logic [NUM_KW-1:0]          alive_d;
	logic [3:0]                 pos_d, hex_cnt_d;
	logic                       hex_stop_d;
	logic                       res_valid;
	cdcp_pkg::rsp_t             res;

	logic                       accept, rsp_load;
	logic [cdcp_pkg::POS_W-1:0] w_last, h_last;
	logic [3:0]                 match;
	logic                       found;
	logic [4:0]                 digit;

	function automatic logic [cdcp_pkg::DIM_W-1:0] dim_clamp(
		input logic [cdcp_pkg::DIM_W-1:0] v
	);
		if (v == '0) begin
			return cdcp_pkg::DIM_W'(1);
		end else if (v > cdcp_pkg::MAX_DIM) begin
			return cdcp_pkg::MAX_DIM;
		end
		return v;
	endfunction

	// value of a hex digit, 16 for any other byte
	function automatic logic [4:0] hex_value(input logic [7:0] b);
		if (b inside {[8'h30:8'h39]}) begin
			return 5'(b - 8'h30);
		end else if (b inside {[8'h41:8'h46]}) begin
			return 5'(b - 8'h37);
		end else if (b inside {[8'h61:8'h66]}) begin
			return 5'(b - 8'h57);
		end
		return HEX_NONE;
	endfunction

	assign accept    = cmd_valid && !cmd_stall;
	assign cmd_stall = rsp_valid_q && rsp_stall;
	assign rsp_load  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// sizes are at least one, so size minus one fits the cursor width
	assign w_last = cdcp_pkg::POS_W'(canvas_w_q - cdcp_pkg::DIM_W'(1));
	assign h_last = cdcp_pkg::POS_W'(canvas_h_q - cdcp_pkg::DIM_W'(1));

	assign digit = hex_value(cmd.line_byte);

	always_comb begin
		match = KW_NONE;
		found = 1'b0;
		for (int k = 0; k < NUM_KW; k++) begin
			if (!found && alive_q[k] && pos_q >= KW_LEN[k]) begin
				found = 1'b1;
				match = 4'(k);
			end
		end
	end

	always_comb begin
		cursor_x_d = cursor_x_q;
		cursor_y_d = cursor_y_q;
		color_d    = color_q;
		pixels_d   = pixels_q;
		alive_d    = alive_q;
		pos_d      = pos_q;
		hex_acc_d  = hex_acc_q;
		hex_cnt_d  = hex_cnt_q;
		hex_stop_d = hex_stop_q;
		res_valid  = 1'b0;
		res        = '0;
		res.result_kind = cdcp_pkg::KIND_ERROR;
		res.error_code  = cdcp_pkg::ERR_EMPTY;
		res.pixel_total = pixels_q;

		if (cmd.line_byte != 8'h00) begin
			for (int k = 0; k < NUM_KW; k++) begin
				if (pos_q < KW_LEN[k] && cmd.line_byte != KW_TEXT[k][pos_q[2:0]]) begin
					alive_d[k] = 1'b0;
				end
			end
			if (pos_q >= HEX_START && !hex_stop_q) begin
				if (digit != HEX_NONE) begin
					if (hex_cnt_q < HEX_KEEP) begin
						hex_acc_d = {hex_acc_q[27:0], digit[3:0]};
					end
					if (hex_cnt_q < HEX_MAX) begin
						hex_cnt_d = hex_cnt_q + 4'd1;
					end
				end else begin
					hex_stop_d = 1'b1;
				end
			end
			if (pos_q < POS_MAX) begin
				pos_d = pos_q + 4'd1;
			end
		end else begin
			alive_d    = '1;
			pos_d      = '0;
			hex_acc_d  = '0;
			hex_cnt_d  = '0;
			hex_stop_d = 1'b0;
			res_valid  = 1'b1;
			if (pos_q != '0) begin
				case (match)
					KW_RESET: begin
						res_valid  = 1'b0;
						cursor_x_d = (cmd.rand_x > w_last) ? w_last : cmd.rand_x;
						cursor_y_d = (cmd.rand_y > h_last) ? h_last : cmd.rand_y;
						color_d    = {cmd.rand_rgb, 8'hFF};
					end
					KW_LEFT, KW_RIGHT, KW_UP, KW_DOWN: begin
						pixels_d        = pixels_q + 32'd1;
						res.result_kind = cdcp_pkg::KIND_PIXEL;
						res.out_x       = cdcp_pkg::DIM_W'(cursor_x_q);
						res.out_y       = cdcp_pkg::DIM_W'(cursor_y_q);
						res.out_color   = color_q;
						res.pixel_total = pixels_d;
						case (match)
							KW_LEFT:  cursor_x_d = (cursor_x_q == '0) ? w_last
								: cursor_x_q - cdcp_pkg::POS_W'(1);
							KW_RIGHT: cursor_x_d = (cursor_x_q >= w_last) ? '0
								: cursor_x_q + cdcp_pkg::POS_W'(1);
							KW_UP:    cursor_y_d = (cursor_y_q == '0) ? h_last
								: cursor_y_q - cdcp_pkg::POS_W'(1);
							default:  cursor_y_d = (cursor_y_q >= h_last) ? '0
								: cursor_y_q + cdcp_pkg::POS_W'(1);
						endcase
					end
					KW_COLOR: begin
						case (hex_cnt_q)
							4'd0: res.error_code = cdcp_pkg::ERR_NO_COLOR;
							4'd2: begin
								res_valid = 1'b0;
								color_d   = {hex_acc_q[7:0], hex_acc_q[7:0],
									hex_acc_q[7:0], 8'hFF};
							end
							4'd6: begin
								res_valid = 1'b0;
								color_d   = {hex_acc_q[23:0], 8'hFF};
							end
							4'd8: begin
								res_valid = 1'b0;
								color_d   = hex_acc_q;
							end
							default: res.error_code = cdcp_pkg::ERR_BAD_LEN;
						endcase
					end
					KW_INFO: begin
						res.result_kind = cdcp_pkg::KIND_INFO;
						res.out_x       = cdcp_pkg::DIM_W'(cursor_x_q);
						res.out_y       = cdcp_pkg::DIM_W'(cursor_y_q);
						res.out_color   = color_q;
					end
					KW_SIZE: begin
						res.result_kind = cdcp_pkg::KIND_SIZE;
						res.out_x       = canvas_w_q;
						res.out_y       = canvas_h_q;
					end
					KW_STATS: res.result_kind = cdcp_pkg::KIND_STATS;
					KW_HELP:  res.result_kind = cdcp_pkg::KIND_HELP;
					default:  res.error_code  = cdcp_pkg::ERR_UNKNOWN;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			canvas_w_q  <= 13'd1024;
			canvas_h_q  <= 13'd768;
			cursor_x_q  <= '0;
			cursor_y_q  <= '0;
			color_q     <= 32'h0000_00FF;
			pixels_q    <= '0;
			alive_q     <= '1;
			pos_q       <= '0;
			hex_acc_q   <= '0;
			hex_cnt_q   <= '0;
			hex_stop_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					cdcp_pkg::CFG_WIDTH:  canvas_w_q <= dim_clamp(cfg_data);
					cdcp_pkg::CFG_HEIGHT: canvas_h_q <= dim_clamp(cfg_data);
					default: ;
				endcase
			end
			if (accept) begin
				cursor_x_q <= cursor_x_d;
				cursor_y_q <= cursor_y_d;
				color_q    <= color_d;
				pixels_q   <= pixels_d;
				alive_q    <= alive_d;
				pos_q      <= pos_d;
				hex_acc_q  <= hex_acc_d;
				hex_cnt_q  <= hex_cnt_d;
				hex_stop_q <= hex_stop_d;
			end
			if (rsp_load) begin
				rsp_valid_q <= accept && res_valid;
			end
		end
	end

	// result word, no reset needed
	always_ff @(posedge clk) begin
		if (rsp_load && accept && res_valid) begin
			rsp_q <= res;
		end
	end

endmodule

`default_nettype wire

>>> design/cdcp_checker.sv
// port-level checks of the command parser, bound to the top level
`default_nettype none

`include "cursor_drawing_command_parser_core_defines.svh"

module cdcp_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       cmd_valid,
	input logic                       cmd_stall,
	input cdcp_pkg::cmd_t             cmd,
	input logic                       rsp_valid,
	input logic                       rsp_stall,
	input cdcp_pkg::rsp_t             rsp
);

	// a held result word stays put
	`CDCP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "rsp word changed while stalled")

	// a fresh result only follows an accepted end-of-line byte
	`CDCP_ASSERT_NOW(a_rsp_from_eol, rsp_valid && !$past(rsp_valid && rsp_stall), $past(cmd_valid && !cmd_stall && cmd.line_byte == 8'h00), "result without end of line")

	// only errors carry an error code
	`CDCP_ASSERT_NOW(a_err_code, rsp_valid && rsp.result_kind != cdcp_pkg::KIND_ERROR, rsp.error_code == cdcp_pkg::ERR_EMPTY, "error code on non-error result")

	// reported canvas size is always a usable size
	`CDCP_ASSERT_NOW(a_size_range, rsp_valid && rsp.result_kind == cdcp_pkg::KIND_SIZE, rsp.out_x != '0 && rsp.out_y != '0 && rsp.out_x <= cdcp_pkg::MAX_DIM && rsp.out_y <= cdcp_pkg::MAX_DIM, "size out of range")

endmodule

bind cursor_drawing_command_parser_core cdcp_checker u_cdcp_checker (.*);

`default_nettype wire

>>> test/tb_cursor_drawing_command_parser_core.sv
// self-checking testbench of the cursor drawing command parser core
module tb_cursor_drawing_command_parser_core;
	import cdcp_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int NUM_CMDS = 10;

	typedef enum int {
		CMD_RESET, CMD_LEFT, CMD_RIGHT, CMD_UP, CMD_DOWN,
		CMD_COLOR, CMD_INFO, CMD_SIZE, CMD_STATS, CMD_HELP, CMD_NONE
	} command_t;

	// keywords in match priority order, indexed by command_t
	string command_words [NUM_CMDS] = '{"RESET", "LEFT", "RIGHT", "UP", "DOWN",
		"COLOR ", "INFO", "SIZE", "STATS", "HELP"};
	string hex_chars = "0123456789abcdefABCDEF";

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic             cfg_index;
	logic [DIM_W-1:0] cfg_data;
	logic             cmd_valid;
	logic             cmd_stall;
	cmd_t             cmd;
	logic             rsp_valid;
	logic             rsp_stall = 1'b0;
	rsp_t             rsp;

	// model of the block
	logic [DIM_W-1:0]    canvas_w = 13'd1024;
	logic [DIM_W-1:0]    canvas_h = 13'd768;
	logic [POS_W-1:0]    cur_x = '0;
	logic [POS_W-1:0]    cur_y = '0;
	logic [31:0]         pen_color = 32'h000000FF;
	logic [31:0]         pixel_count = '0;
	logic [NUM_CMDS-1:0] alive = '1;
	logic [3:0]          line_pos = '0;
	logic [31:0]         hex_acc = '0;
	logic [3:0]          hex_cnt = '0;
	logic                hex_stop = 1'b0;

	rsp_t pending_results[$];
	int   mismatch_count = 0;
	int   bytes_sent = 0;
	int   quiet_cycles = 0;
	bit   jitter_on = 1'b0;

	cursor_drawing_command_parser_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		rsp_stall <= jitter_on && ($urandom_range(99) < 37);
	end

	function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_DIM)
			return MAX_DIM;
		return v;
	endfunction

	// 16 means not a hex digit
	function automatic logic [4:0] hex_value(input logic [7:0] b);
		if (b >= "0" && b <= "9")
			return 5'(b - "0");
		if (b >= "A" && b <= "F")
			return 5'(b - "A" + 10);
		if (b >= "a" && b <= "f")
			return 5'(b - "a" + 10);
		return 5'd16;
	endfunction

	function automatic void parse_byte(input cmd_t c);
		int unsigned w, h;
		int k;
		logic [4:0] digit;
		command_t hit;
		rsp_t r;
		logic emit;
		w = eff_dim(canvas_w);
		h = eff_dim(canvas_h);
		if (c.line_byte != 8'd0) begin
			for (k = 0; k < NUM_CMDS; k++)
				if (line_pos < command_words[k].len() &&
						c.line_byte != command_words[k][line_pos])
					alive[k] = 1'b0;
			if (line_pos >= 6 && !hex_stop) begin
				digit = hex_value(c.line_byte);
				if (digit < 5'd16) begin
					if (hex_cnt < 8)
						hex_acc = {hex_acc[27:0], digit[3:0]};
					if (hex_cnt < 9)
						hex_cnt++;
				end else
					hex_stop = 1'b1;
			end
			if (line_pos < 15)
				line_pos++;
			return;
		end
		r = '0;
		emit = 1'b1;
		hit = CMD_NONE;
		// scan from the lowest priority so the first live keyword wins
		for (k = NUM_CMDS - 1; k >= 0; k--)
			if (alive[k] && line_pos >= command_words[k].len())
				hit = command_t'(k);
		if (line_pos == 0) begin
			r.result_kind = KIND_ERROR;
			r.error_code = ERR_EMPTY;
		end else begin
			case (hit)
				CMD_RESET: begin
					cur_x = (c.rand_x > w - 1) ? POS_W'(w - 1) : c.rand_x;
					cur_y = (c.rand_y > h - 1) ? POS_W'(h - 1) : c.rand_y;
					pen_color = {c.rand_rgb, 8'hFF};
					emit = 1'b0;
				end
				CMD_LEFT, CMD_RIGHT, CMD_UP, CMD_DOWN: begin
					pixel_count++;
					r.result_kind = KIND_PIXEL;
					r.out_x = {1'b0, cur_x};
					r.out_y = {1'b0, cur_y};
					r.out_color = pen_color;
					if (hit == CMD_LEFT)
						cur_x = (cur_x == 0) ? POS_W'(w - 1) : cur_x - 1'b1;
					else if (hit == CMD_RIGHT)
						cur_x = (cur_x >= w - 1) ? '0 : cur_x + 1'b1;
					else if (hit == CMD_UP)
						cur_y = (cur_y == 0) ? POS_W'(h - 1) : cur_y - 1'b1;
					else
						cur_y = (cur_y >= h - 1) ? '0 : cur_y + 1'b1;
				end
				CMD_COLOR: begin
					emit = 1'b0;
					case (hex_cnt)
						4'd2: pen_color = hex_acc * 32'h01010100 + 32'hFF;
						4'd6: pen_color = (hex_acc << 8) + 32'hFF;
						4'd8: pen_color = hex_acc;
						default: begin
							emit = 1'b1;
							r.result_kind = KIND_ERROR;
							r.error_code = (hex_cnt == 0) ? ERR_NO_COLOR : ERR_BAD_LEN;
						end
					endcase
				end
				CMD_INFO: begin
					r.result_kind = KIND_INFO;
					r.out_x = {1'b0, cur_x};
					r.out_y = {1'b0, cur_y};
					r.out_color = pen_color;
				end
				CMD_SIZE: begin
					r.result_kind = KIND_SIZE;
					r.out_x = DIM_W'(w);
					r.out_y = DIM_W'(h);
				end
				CMD_STATS: r.result_kind = KIND_STATS;
				CMD_HELP: r.result_kind = KIND_HELP;
				default: begin
					r.result_kind = KIND_ERROR;
					r.error_code = ERR_UNKNOWN;
				end
			endcase
		end
		r.pixel_total = pixel_count;
		if (emit)
			pending_results.push_back(r);
		alive = '1;
		line_pos = '0;
		hex_acc = '0;
		hex_cnt = '0;
		hex_stop = 1'b0;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic compare_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	// result check first, so a word accepted in the same cycle cannot be taken for it
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_results.size() == 0)
					report_mismatch($sformatf("result with none expected, kind %0d",
						rsp.result_kind));
				else begin
					want = pending_results.pop_front();
					compare_field("result_kind", rsp.result_kind, want.result_kind);
					compare_field("out_x", rsp.out_x, want.out_x);
					compare_field("out_y", rsp.out_y, want.out_y);
					compare_field("out_color", rsp.out_color, want.out_color);
					compare_field("pixel_total", rsp.pixel_total, want.pixel_total);
					compare_field("error_code", rsp.error_code, want.error_code);
				end
			end
			if (cmd_valid && !cmd_stall)
				parse_byte(cmd);
			if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb_cursor_drawing_command_parser_core failed");
				$finish;
			end
		end
	end

	task automatic send_word(input cmd_t c);
		while (jitter_on && $urandom_range(99) < 37) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
	endtask

	// sends the text and then the zero byte that ends the line
	task automatic send_bytes(input logic [7:0] text[$]);
		cmd_t c;
		int i;
		for (i = 0; i <= text.size(); i++) begin
			c.line_byte = (i < text.size()) ? text[i] : 8'd0;
			c.rand_x = POS_W'($urandom);
			c.rand_y = POS_W'($urandom);
			c.rand_rgb = 24'($urandom);
			send_word(c);
		end
		bytes_sent += text.size() + 1;
	endtask

	task automatic send_line(input string s);
		logic [7:0] text[$];
		int i;
		for (i = 0; i < s.len(); i++)
			text.push_back(s[i]);
		send_bytes(text);
	endtask

	// stop sending and let every expected word come out
	task automatic settle();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_canvas(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= CFG_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		cfg_index <= CFG_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
		canvas_w = w;
		canvas_h = h;
	endtask

	task automatic test_commands();
		logic [7:0] junk[$];
		jitter_on = 1'b1;
		send_line("");
		send_line("HELP");
		send_line("STATS");
		send_line("SIZE");
		send_line("INFO");
		// left and up wrap from zero at once
		send_line("LEFT");
		send_line("UP");
		send_line("RIGHT");
		send_line("DOWN");
		send_line("RESET");
		send_line("INFO");
		send_line("RES");
		send_line("COLOR");
		send_line("XYZZY");
		send_line("LEFTOVER");
		send_line("UPSIDE");
		// longer than the position counter
		send_line("HELPHELPHELPHELPHELP");
		junk = '{8'hFF, 8'h80, 8'h01};
		send_bytes(junk);
	endtask

	task automatic test_colors();
		send_line("COLOR ");
		send_line("COLOR 7f");
		send_line("LEFT");
		send_line("COLOR A1b2C3");
		send_line("INFO");
		send_line("COLOR 12345678");
		send_line("INFO");
		send_line("COLOR 123");
		send_line("COLOR 123456789A");
		send_line("COLOR 12G34");
		send_line("INFO");
		send_line("COLOR ffffffff");
		send_line("COLOR 00000000");
		send_line("DOWN");
		send_line("COLOR xyz");
	endtask

	task automatic test_canvas();
		int i;
		set_canvas(13'd1, 13'd1);
		send_line("SIZE");
		send_line("RIGHT");
		send_line("UP");
		send_line("RESET");
		send_line("INFO");
		set_canvas(13'd0, 13'd0);
		send_line("SIZE");
		send_line("LEFT");
		set_canvas(13'h1FFF, 13'h1FFF);
		send_line("SIZE");
		set_canvas(13'd4096, 13'd4096);
		send_line("RESET");
		send_line("INFO");
		// cursor now likely outside the shrunk canvas
		set_canvas(13'd5, 13'd3);
		send_line("LEFT");
		send_line("UP");
		send_line("INFO");
		send_line("RESET");
		for (i = 0; i < 6; i++) begin
			send_line("RIGHT");
			send_line("DOWN");
		end
		send_line("SIZE");
	endtask

	task automatic run_random(input int budget);
		logic [7:0] text[$];
		string word;
		int i, n, stop_at;
		stop_at = bytes_sent + budget;
		while (bytes_sent < stop_at) begin
			text.delete();
			if ($urandom_range(99) < 80) begin
				word = command_words[$urandom_range(0, NUM_CMDS - 1)];
				for (i = 0; i < word.len(); i++)
					text.push_back(word[i]);
				if (word == "COLOR ") begin
					n = $urandom_range(0, 10);
					for (i = 0; i < n; i++)
						text.push_back(hex_chars[$urandom_range(0, 21)]);
				end
				if ($urandom_range(9) < 3)
					repeat ($urandom_range(1, 4))
						text.push_back(8'($urandom_range(32, 126)));
				// cut lines short now and then
				if ($urandom_range(9) == 0)
					void'(text.pop_back());
			end else
				repeat ($urandom_range(0, 18))
					text.push_back(8'($urandom_range(1, 255)));
			send_bytes(text);
		end
	endtask

	task automatic test_random();
		jitter_on = 1'b0;
		set_canvas(13'd1024, 13'd768);
		run_random(150);
		jitter_on = 1'b1;
		set_canvas(DIM_W'($urandom_range(1, 8)), DIM_W'($urandom_range(1, 8)));
		run_random(75);
		settle();
		run_random(75);
		set_canvas(13'd4096, DIM_W'($urandom_range(1, 4096)));
		run_random(150);
		set_canvas(DIM_W'($urandom_range(0, 8191)), DIM_W'($urandom_range(0, 8191)));
		run_random(150);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_WIDTH;
		cfg_data = '0;
		cmd_valid = 1'b0;
		cmd = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_commands();
		test_colors();
		test_canvas();
		test_random();
		settle();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_cursor_drawing_command_parser_core passed");
		else
			$display("tb_cursor_drawing_command_parser_core failed");
		$finish;
	end

endmodule

>>> files.f
+incdir+design
design/cdcp_pkg.sv
design/cursor_drawing_command_parser_core.sv
design/cdcp_checker.sv
test/tb_cursor_drawing_command_parser_core.sv
